// File: src/friction_cone_projection_assert.svh
// Assertion macros for the friction cone projection RTL.
`ifndef FRICTION_CONE_PROJECTION_ASSERT_SVH
`define FRICTION_CONE_PROJECTION_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FCP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("friction cone projection check failed");

// next-cycle implication, disabled in reset
`define FCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("friction cone projection check failed");

`endif

// File: src/fcp_pkg.sv
// Package: fixed-point types, saturating arithmetic and the pipeline record.
`timescale 1ns / 1ps
package fcp_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;
  localparam int DIV_LAT   = QUOT_BITS + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t FX_ONE   = word_t'(64'(1) << FRAC_BITS);

  typedef enum logic [1:0] {
    REG_STICK    = 2'd0,
    REG_SLIDE    = 2'd1,
    REG_SEPARATE = 2'd2
  } region_e;

  typedef struct packed {
    word_t   y1;
    word_t   y2;
    word_t   yn;
    word_t   yr;
    word_t   d1;
    word_t   d2;
    word_t   mu;
    word_t   rt;
    word_t   rn;
    word_t   mu_yn;
    word_t   m_rt;
    word_t   p11;
    word_t   p12;
    word_t   p22;
    word_t   q11;
    word_t   n12;
    word_t   q22;
    word_t   mu_hat;
    word_t   yr_mu;
    word_t   mu_mh;
    word_t   mh_yr;
    word_t   den;
    word_t   s;
    word_t   nmh;
    region_e region;
    word_t   factor;
    word_t   gn;
    word_t   a;
    word_t   muf;
    word_t   mugn;
    word_t   gy;
    word_t   t11;
    word_t   t12;
    word_t   t22;
    word_t   ap11;
    word_t   ap12;
    word_t   ap22;
    word_t   g1;
    word_t   g2;
    word_t   jtn1;
    word_t   jtn2;
    word_t   jnt1;
    word_t   jnt2;
    word_t   u11;
    word_t   u12;
    word_t   u22;
    word_t   j11;
    word_t   j12;
    word_t   j22;
  } rec_t;

  function automatic logic [WORD_BITS-1:0] fx_mag(input word_t a);
    logic [WORD_BITS-1:0] u;
    u = a;
    return a[WORD_BITS-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic word_t fx_sat(input logic neg, input logic [QUOT_BITS-1:0] m);
    logic [QUOT_BITS-1:0] lim;
    logic [WORD_BITS-1:0] v;
    lim = QUOT_BITS'(WORD_MAX) + QUOT_BITS'(neg);
    v = (m > lim) ? lim[WORD_BITS-1:0] : m[WORD_BITS-1:0];
    return neg ? word_t'(-v) : word_t'(v);
  endfunction

  function automatic word_t fx_mul(input word_t a, input word_t b);
    logic [2*WORD_BITS-1:0] p;
    p = fx_mag(a) * fx_mag(b);
    return fx_sat(a[WORD_BITS-1] ^ b[WORD_BITS-1], p[2*WORD_BITS-1:FRAC_BITS]);
  endfunction

  function automatic word_t fx_add(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t fx_neg(input word_t a);
    return (a == WORD_MIN) ? WORD_MAX : word_t'(-a);
  endfunction

endpackage

// File: src/fcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating Q result.
`timescale 1ns / 1ps
module fcp_div import fcp_pkg::*; (
  input  logic  clk_i,
  input  word_t num_i,
  input  word_t den_i,
  output word_t quo_o
);

  logic [QUOT_BITS-1:0] nq_q   [QUOT_BITS+1];
  logic [WORD_BITS-1:0] rem_q  [QUOT_BITS+1];
  logic [WORD_BITS-1:0] dv_q   [QUOT_BITS+1];
  logic                 neg_q  [QUOT_BITS+1];
  logic                 zero_q [QUOT_BITS+1];
  word_t                quo_q;

  always_ff @(posedge clk_i) begin
    nq_q[0]   <= {fx_mag(num_i), FRAC_BITS'(0)};
    rem_q[0]  <= '0;
    dv_q[0]   <= fx_mag(den_i);
    neg_q[0]  <= num_i[WORD_BITS-1] ^ den_i[WORD_BITS-1];
    zero_q[0] <= (num_i == '0);
  end

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
    logic [WORD_BITS:0] rs;
    logic [WORD_BITS:0] rd;
    logic               ge;

    assign rs = {rem_q[i], nq_q[i][QUOT_BITS-1]};
    assign rd = rs - {1'b0, dv_q[i]};
    assign ge = (rs >= {1'b0, dv_q[i]});

    always_ff @(posedge clk_i) begin
      rem_q[i+1]  <= ge ? rd[WORD_BITS-1:0] : rs[WORD_BITS-1:0];
      nq_q[i+1]   <= {nq_q[i][QUOT_BITS-2:0], ge};
      dv_q[i+1]   <= dv_q[i];
      neg_q[i+1]  <= neg_q[i];
      zero_q[i+1] <= zero_q[i];
    end
  end

  // divide by zero leaves all ones in the quotient, which saturates; a zero numerator gives zero
  always_ff @(posedge clk_i) begin
    quo_q <= zero_q[QUOT_BITS] ? '0 : fx_sat(neg_q[QUOT_BITS], nq_q[QUOT_BITS]);
  end

  assign quo_o = quo_q;

endmodule

// File: src/fcp_delay.sv
// Delay line that carries the contact record and its valid bit past a divider.
`timescale 1ns / 1ps
module fcp_delay import fcp_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = DIV_LAT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             vld_o,
  output logic [WIDTH-1:0] data_o
);

  logic             vld_q  [DEPTH];
  logic [WIDTH-1:0] data_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < DEPTH; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    data_q[0] <= data_i;
    for (int k = 1; k < DEPTH; k++) data_q[k] <= data_q[k-1];
  end

  assign vld_o  = vld_q[DEPTH-1];
  assign data_o = data_q[DEPTH-1];

endmodule

// File: src/friction_cone_projection.sv
// Top level: pipelined friction cone projection, one contact per beat.
// Takes one contact in every clock cycle; busy is always low. Each result appears on the
// output ports for exactly one cycle with done_o high, after its start beat
// (12 arithmetic and register stages plus three divider levels of 50 stages each: the
// divisions mu*Rt/Rn and yr/mu run in parallel, then 1/(1+mu*mu_hat), then gn/yr,
// each producing one of 48 quotient bits per stage). Results leave in start order and
// the receiver must take each one in its cycle; there is no hold-off.
`timescale 1ns / 1ps
`include "friction_cone_projection_assert.svh"
module friction_cone_projection import fcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  word_t       y_t1_i,
  input  word_t       y_t2_i,
  input  word_t       y_normal_i,
  input  logic [30:0] y_radial_i,
  input  logic signed [17:0] dir_t1_i,
  input  logic signed [17:0] dir_t2_i,
  input  logic [30:0] friction_coef_i,
  input  logic [30:0] reg_tangent_i,
  input  logic [30:0] reg_normal_i,
  output logic        done_o,
  output word_t       gamma_t1_o,
  output word_t       gamma_t2_o,
  output word_t       gamma_normal_o,
  output logic [1:0]  region_o,
  output word_t       jac_tt11_o,
  output word_t       jac_tt12_o,
  output word_t       jac_tt22_o,
  output word_t       jac_tn1_o,
  output word_t       jac_tn2_o,
  output word_t       jac_nt1_o,
  output word_t       jac_nt2_o,
  output word_t       jac_nn_o
);

  localparam int PIPE_LAT = 12 + 3 * DIV_LAT;
  localparam int REC_BITS = $bits(rec_t);

  rec_t r0_d, r0_q, r1_d, r1_q, r2_d, r2_q, r3_d, r3_q, r4_d, r4_q;
  rec_t r5_d, r5_q, r6_d, r6_q, r7_d, r7_q, r8_d, r8_q, r9_d, r9_q, r10_d, r10_q;
  rec_t ra, rc, rd;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic va, vc, vd;
  word_t qa, qb, qc, qd;

  logic    done_q;
  word_t   gamma_t1_q, gamma_t2_q, gamma_normal_q;
  region_e region_q;
  word_t   jac_tt11_q, jac_tt12_q, jac_tt22_q, jac_tn1_q, jac_tn2_q;
  word_t   jac_nt1_q, jac_nt2_q, jac_nn_q;

  assign busy = 1'b0;

  always_comb begin
    r0_d    = '0;
    r0_d.y1 = y_t1_i;
    r0_d.y2 = y_t2_i;
    r0_d.yn = y_normal_i;
    r0_d.yr = word_t'({1'b0, y_radial_i});
    r0_d.d1 = word_t'(dir_t1_i);
    r0_d.d2 = word_t'(dir_t2_i);
    r0_d.mu = word_t'({1'b0, friction_coef_i});
    r0_d.rt = word_t'({1'b0, reg_tangent_i});
    r0_d.rn = word_t'({1'b0, reg_normal_i});
  end

  always_comb begin
    r1_d       = r0_q;
    r1_d.mu_yn = fx_mul(r0_q.mu, r0_q.yn);
    r1_d.m_rt  = fx_mul(r0_q.mu, r0_q.rt);
    r1_d.p11   = fx_mul(r0_q.d1, r0_q.d1);
    r1_d.p12   = fx_mul(r0_q.d1, r0_q.d2);
    r1_d.p22   = fx_mul(r0_q.d2, r0_q.d2);
  end

  fcp_div u_div_mu_hat (.clk_i(clk_i), .num_i(r1_q.m_rt), .den_i(r1_q.rn), .quo_o(qa));
  fcp_div u_div_yr_mu  (.clk_i(clk_i), .num_i(r1_q.yr),   .den_i(r1_q.mu), .quo_o(qb));

  fcp_delay #(.WIDTH(REC_BITS), .DEPTH(DIV_LAT)) u_dly_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .vld_i(v1_q), .data_i(r1_q), .vld_o(va), .data_o(ra)
  );

  always_comb begin
    r2_d        = ra;
    r2_d.mu_hat = qa;
    r2_d.yr_mu  = qb;
    r2_d.q11    = fx_add(FX_ONE, fx_neg(ra.p11));
    r2_d.n12    = fx_neg(ra.p12);
    r2_d.q22    = fx_add(FX_ONE, fx_neg(ra.p22));
  end

  always_comb begin
    r3_d       = r2_q;
    r3_d.mu_mh = fx_mul(r2_q.mu, r2_q.mu_hat);
    r3_d.mh_yr = fx_mul(r2_q.mu_hat, r2_q.yr);
  end

  always_comb begin
    r4_d     = r3_q;
    r4_d.den = fx_add(FX_ONE, r3_q.mu_mh);
    r4_d.s   = fx_add(r3_q.yn, r3_q.mh_yr);
    r4_d.nmh = fx_neg(r3_q.mh_yr);
  end

  fcp_div u_div_factor (.clk_i(clk_i), .num_i(FX_ONE), .den_i(r4_q.den), .quo_o(qc));

  fcp_delay #(.WIDTH(REC_BITS), .DEPTH(DIV_LAT)) u_dly_c (
    .clk_i(clk_i), .rst_ni(rst_ni), .vld_i(v4_q), .data_i(r4_q), .vld_o(vc), .data_o(rc)
  );

  // zero mu passes the upper bound of the sliding test
  always_comb begin
    r5_d        = rc;
    r5_d.factor = qc;
    priority if (rc.yr < rc.mu_yn) begin
      r5_d.region = REG_STICK;
    end else if (rc.nmh < rc.yn && (rc.mu == '0 || rc.yn <= rc.yr_mu)) begin
      r5_d.region = REG_SLIDE;
    end else begin
      r5_d.region = REG_SEPARATE;
    end
  end

  always_comb begin
    r6_d     = r5_q;
    r6_d.gn  = fx_mul(r5_q.s, r5_q.factor);
    r6_d.a   = fx_mul(r5_q.mu_hat, r5_q.factor);
    r6_d.muf = fx_mul(r5_q.mu, r5_q.factor);
  end

  fcp_div u_div_gy (.clk_i(clk_i), .num_i(r6_q.gn), .den_i(r6_q.yr), .quo_o(qd));

  fcp_delay #(.WIDTH(REC_BITS), .DEPTH(DIV_LAT)) u_dly_d (
    .clk_i(clk_i), .rst_ni(rst_ni), .vld_i(v6_q), .data_i(r6_q), .vld_o(vd), .data_o(rd)
  );

  always_comb begin
    r7_d      = rd;
    r7_d.gy   = qd;
    r7_d.mugn = fx_mul(rd.mu, rd.gn);
  end

  always_comb begin
    r8_d      = r7_q;
    r8_d.t11  = fx_mul(r7_q.gy, r7_q.q11);
    r8_d.t12  = fx_mul(r7_q.gy, r7_q.n12);
    r8_d.t22  = fx_mul(r7_q.gy, r7_q.q22);
    r8_d.ap11 = fx_mul(r7_q.a, r7_q.p11);
    r8_d.ap12 = fx_mul(r7_q.a, r7_q.p12);
    r8_d.ap22 = fx_mul(r7_q.a, r7_q.p22);
    r8_d.g1   = fx_mul(r7_q.mugn, r7_q.d1);
    r8_d.g2   = fx_mul(r7_q.mugn, r7_q.d2);
    r8_d.jtn1 = fx_mul(r7_q.muf, r7_q.d1);
    r8_d.jtn2 = fx_mul(r7_q.muf, r7_q.d2);
    r8_d.jnt1 = fx_mul(r7_q.a, r7_q.d1);
    r8_d.jnt2 = fx_mul(r7_q.a, r7_q.d2);
  end

  always_comb begin
    r9_d     = r8_q;
    r9_d.u11 = fx_add(r8_q.t11, r8_q.ap11);
    r9_d.u12 = fx_add(r8_q.t12, r8_q.ap12);
    r9_d.u22 = fx_add(r8_q.t22, r8_q.ap22);
  end

  always_comb begin
    r10_d     = r9_q;
    r10_d.j11 = fx_mul(r9_q.mu, r9_q.u11);
    r10_d.j12 = fx_mul(r9_q.mu, r9_q.u12);
    r10_d.j22 = fx_mul(r9_q.mu, r9_q.u22);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      v9_q   <= 1'b0;
      v10_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= start && !busy;
      v1_q   <= v0_q;
      v2_q   <= va;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= vc;
      v6_q   <= v5_q;
      v7_q   <= vd;
      v8_q   <= v7_q;
      v9_q   <= v8_q;
      v10_q  <= v9_q;
      done_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    r2_q  <= r2_d;
    r3_q  <= r3_d;
    r4_q  <= r4_d;
    r5_q  <= r5_d;
    r6_q  <= r6_d;
    r7_q  <= r7_d;
    r8_q  <= r8_d;
    r9_q  <= r9_d;
    r10_q <= r10_d;
  end

  always_ff @(posedge clk_i) begin
    region_q <= r10_q.region;
    unique case (r10_q.region)
      REG_STICK: begin
        gamma_t1_q     <= r10_q.y1;
        gamma_t2_q     <= r10_q.y2;
        gamma_normal_q <= r10_q.yn;
        jac_tt11_q     <= FX_ONE;
        jac_tt12_q     <= '0;
        jac_tt22_q     <= FX_ONE;
        jac_tn1_q      <= '0;
        jac_tn2_q      <= '0;
        jac_nt1_q      <= '0;
        jac_nt2_q      <= '0;
        jac_nn_q       <= FX_ONE;
      end
      REG_SLIDE: begin
        gamma_t1_q     <= r10_q.g1;
        gamma_t2_q     <= r10_q.g2;
        gamma_normal_q <= r10_q.gn;
        jac_tt11_q     <= r10_q.j11;
        jac_tt12_q     <= r10_q.j12;
        jac_tt22_q     <= r10_q.j22;
        jac_tn1_q      <= r10_q.jtn1;
        jac_tn2_q      <= r10_q.jtn2;
        jac_nt1_q      <= r10_q.jnt1;
        jac_nt2_q      <= r10_q.jnt2;
        jac_nn_q       <= r10_q.factor;
      end
      default: begin
        gamma_t1_q     <= '0;
        gamma_t2_q     <= '0;
        gamma_normal_q <= '0;
        jac_tt11_q     <= '0;
        jac_tt12_q     <= '0;
        jac_tt22_q     <= '0;
        jac_tn1_q      <= '0;
        jac_tn2_q      <= '0;
        jac_nt1_q      <= '0;
        jac_nt2_q      <= '0;
        jac_nn_q       <= '0;
      end
    endcase
  end

  assign done_o         = done_q;
  assign gamma_t1_o     = gamma_t1_q;
  assign gamma_t2_o     = gamma_t2_q;
  assign gamma_normal_o = gamma_normal_q;
  assign region_o       = region_q;
  assign jac_tt11_o     = jac_tt11_q;
  assign jac_tt12_o     = jac_tt12_q;
  assign jac_tt22_o     = jac_tt22_q;
  assign jac_tn1_o      = jac_tn1_q;
  assign jac_tn2_o      = jac_tn2_q;
  assign jac_nt1_o      = jac_nt1_q;
  assign jac_nt2_o      = jac_nt2_q;
  assign jac_nn_o       = jac_nn_q;

  `FCP_ASSERT_NEXT(a_latency, start, ##(PIPE_LAT-1) done_o)
  `FCP_ASSERT_IMPL(a_no_spurious, done_o, $past(start, PIPE_LAT))
  `FCP_ASSERT_IMPL(a_stick_pass, done_o && region_o == REG_STICK, gamma_t1_o == $past(y_t1_i, PIPE_LAT) && gamma_normal_o == $past(y_normal_i, PIPE_LAT))

endmodule
